### rtl/core/bc_pkg.sv
package bc_pkg;

  localparam int MAX_VERTICES  = 256;
  localparam int MAX_EDGES     = 1024;
  localparam int FRACTION_BITS = 16;

  localparam int VERT_W  = 8;
  localparam int VCNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int EADDR_W = $clog2(MAX_EDGES);
  localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
  localparam int HOP_W   = VCNT_W;
  localparam int DATA_W  = 32;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int DIVCNT_W = $clog2(PROD_W + 1);

  localparam logic [DATA_W-1:0] SAT32   = '1;
  localparam logic [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRACTION_BITS;

  typedef enum logic [1:0] {
    ACT_CLEAR,
    ACT_ADD,
    ACT_COMPUTE,
    ACT_READ
  } action_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_RANGE,
    ST_NOT_COMPUTED
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RESP, S_CINIT, S_CSRC,
    S_FPOP, S_FPOPW, S_FVLAT, S_FEDGE, S_FEDGEW, S_FCAND, S_FVIS, S_FADV,
    S_BINIT, S_BPOP, S_BPOPW, S_BWLAT, S_BEDGE, S_BEDGEW, S_BCAND, S_BCHK,
    S_BMUL, S_BDIVI, S_BDIV, S_BACC, S_BADV, S_BSRD, S_BSWR
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_ACCEPT, CMD_RESP, CMD_CINIT, CMD_SRC,
    CMD_FPOP, CMD_FPOPW, CMD_FVLAT, CMD_EDGE, CMD_EDGEW, CMD_FCAND, CMD_FVIS,
    CMD_ADV, CMD_BINIT, CMD_BPOP, CMD_BPOPW, CMD_BWLAT, CMD_BCAND, CMD_BCHK,
    CMD_BMUL, CMD_DIVSTART, CMD_BACC, CMD_SRD, CMD_SWR
  } cmd_t;

  typedef struct packed {
    logic queue_empty;
    logic edges_done;
    logic fwd_hit;
    logic bwd_hit;
    logic last_side;
    logic acc_ok;
    logic div_done;
    logic index_zero;
    logic w_is_src;
    logic sources_done;
    logic out_pending;
  } dp_stat_t;

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? SAT32 : s[DATA_W-1:0];
  endfunction

endpackage

### rtl/core/bc_if.sv
interface bc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] vertex_a;
  logic [7:0] vertex_b;
  modport source(output valid, action, vertex_a, vertex_b, input ready);
  modport sink(input valid, action, vertex_a, vertex_b, output ready);
endinterface

interface bc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [8:0]  vertex_count;
  logic [31:0] centrality;
  modport source(output valid, status, vertex_count, centrality, input ready);
  modport sink(input valid, status, vertex_count, centrality, output ready);
endinterface

interface bc_cfg_if;
  logic valid;
  logic ready;
  logic directed_mode;
  modport source(output valid, directed_mode, input ready);
  modport sink(input valid, directed_mode, output ready);
endinterface

### rtl/core/bc_div.sv
module bc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bc_pkg::PROD_W-1:0]   dividend,
  input  logic [bc_pkg::DATA_W-1:0]   divisor,
  output logic                        busy,
  output logic [bc_pkg::PROD_W-1:0]   quotient
);

  logic [bc_pkg::DIVCNT_W-1:0] cnt_r;
  logic [bc_pkg::PROD_W-1:0]   quo_r;
  logic [bc_pkg::DATA_W-1:0]   rem_r;
  logic [bc_pkg::DATA_W:0]     trial;
  logic                        take;

  always_comb begin
    trial = {rem_r, quo_r[bc_pkg::PROD_W-1]};
    take  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= bc_pkg::DIVCNT_W'(bc_pkg::PROD_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[bc_pkg::PROD_W-2:0], take};
      rem_r <= take ? bc_pkg::DATA_W'(trial - {1'b0, divisor})
                    : trial[bc_pkg::DATA_W-1:0];
    end
  end

  assign busy     = cnt_r != '0;
  assign quotient = quo_r;

endmodule

### rtl/core/bc_datapath.sv
module bc_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bc_pkg::cmd_t                  cmd,
  output bc_pkg::dp_stat_t              stat,
  input  logic [1:0]                    in_action,
  input  logic [bc_pkg::VERT_W-1:0]     in_vertex_a,
  input  logic [bc_pkg::VERT_W-1:0]     in_vertex_b,
  input  logic                          cfg_we,
  input  logic                          cfg_directed,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [bc_pkg::VCNT_W-1:0]     out_vertex_count,
  output logic [bc_pkg::DATA_W-1:0]     out_centrality
);

  localparam int VW = bc_pkg::VERT_W;
  localparam int DW = bc_pkg::DATA_W;
  localparam int HW = bc_pkg::HOP_W;
  localparam int NV = bc_pkg::MAX_VERTICES;

  logic [2*VW-1:0] edge_mem [bc_pkg::MAX_EDGES];
  logic [HW-1:0]   hd_mem   [NV];
  logic [DW-1:0]   pc_mem   [NV];
  logic [DW-1:0]   dep_mem  [NV];
  logic [DW-1:0]   score_mem[NV];
  logic [VW-1:0]   vo_mem   [NV];

  logic [2*VW-1:0] edge_rd_r;
  logic [HW-1:0]   hd_rd_r;
  logic [DW-1:0]   pc_rd_r, dep_rd_r, score_rd_r;
  logic [VW-1:0]   vo_rd_r;
  logic            live_rd_r;

  logic                       directed_r, halve_r, sv_r;
  logic [bc_pkg::ECNT_W-1:0]  ec_r, e_r;
  logic [bc_pkg::VCNT_W-1:0]  vs_r, s_r, head_r, tail_r, i_r;
  logic [NV-1:0]              reached_r, live_r;
  logic [1:0]                 act_r, st_r;
  logic [VW-1:0]              va_r, v_r, w_r, a_r, b_r;
  logic                       side_r;
  logic [HW-1:0]              hdv_r, hdw_r;
  logic [DW-1:0]              pcv_r, pcw_r, depw_r, depv_r, oneplus_r;
  logic [bc_pkg::PROD_W-1:0]  prod_r;
  logic                       out_valid_r;
  logic [1:0]                 out_status_r;
  logic [bc_pkg::VCNT_W-1:0]  out_count_r;
  logic [DW-1:0]              out_cent_r;

  logic            undirected, fwd_hit, bwd_hit, acc_ok, full, div_busy, src_done;
  logic [VW-1:0]   fcand_w, bcand_v, vrd_addr, vwr_addr, score_addr;
  logic [HW-1:0]   hdv_p1;
  logic            vrd_en, hd_we, pc_we, dep_we, vo_we, edge_we, edge_re, score_re;
  logic [HW-1:0]   hd_wd;
  logic [DW-1:0]   pc_wd, dep_wd, term, score_base, score_val;
  logic [VW-1:0]   vo_wa, vo_wd;
  logic [bc_pkg::VCNT_W-1:0] top_v;
  logic [bc_pkg::PROD_W-1:0] quotient;
  logic            div_start, new_w;

  bc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (pcw_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_comb begin
    src_done   = s_r >= vs_r;
    undirected = !directed_r;
    fcand_w    = side_r ? a_r : b_r;
    fwd_hit    = side_r ? (undirected && b_r == v_r) : (a_r == v_r);
    bcand_v    = side_r ? b_r : a_r;
    bwd_hit    = (side_r ? (undirected && a_r == w_r) : (b_r == w_r)) &&
                 reached_r[bcand_v] && pcw_r != '0;
    hdv_p1     = hdv_r + 1'b1;
    acc_ok     = HW'(hd_rd_r + 1'b1) == hdw_r;
    full       = ec_r >= bc_pkg::ECNT_W'(bc_pkg::MAX_EDGES);
    term       = (quotient[bc_pkg::PROD_W-1:DW] != '0) ? bc_pkg::SAT32
                                                        : quotient[DW-1:0];
    new_w      = !reached_r[w_r];
    div_start  = cmd == bc_pkg::CMD_DIVSTART;
    top_v      = ((in_vertex_a > in_vertex_b) ? {1'b0, in_vertex_a}
                                              : {1'b0, in_vertex_b}) + 1'b1;
    score_base = live_rd_r ? score_rd_r : '0;
    score_val  = halve_r ? (score_base >> 1) : score_base;

    case (cmd)
      bc_pkg::CMD_FPOPW, bc_pkg::CMD_BPOPW: vrd_addr = vo_rd_r;
      bc_pkg::CMD_FCAND:                   vrd_addr = fcand_w;
      bc_pkg::CMD_BCAND:                   vrd_addr = bcand_v;
      default:                             vrd_addr = vo_rd_r;
    endcase
    vrd_en = cmd == bc_pkg::CMD_FPOPW || cmd == bc_pkg::CMD_BPOPW ||
             cmd == bc_pkg::CMD_FCAND || cmd == bc_pkg::CMD_BCAND;

    vwr_addr = (cmd == bc_pkg::CMD_SRC) ? s_r[VW-1:0] :
               (cmd == bc_pkg::CMD_BACC) ? v_r : w_r;
    hd_we  = (cmd == bc_pkg::CMD_SRC && !src_done) ||
             (cmd == bc_pkg::CMD_FVIS && new_w);
    hd_wd  = (cmd == bc_pkg::CMD_SRC) ? '0 : hdv_p1;
    pc_we  = (cmd == bc_pkg::CMD_SRC && !src_done) ||
             (cmd == bc_pkg::CMD_FVIS && (new_w || hd_rd_r == hdv_p1));
    pc_wd  = (cmd == bc_pkg::CMD_SRC) ? DW'(1) :
             new_w ? pcv_r : bc_pkg::sat_add(pc_rd_r, pcv_r);
    dep_we = hd_we || cmd == bc_pkg::CMD_BACC;
    dep_wd = (cmd == bc_pkg::CMD_BACC) ? bc_pkg::sat_add(depv_r, term) : '0;
    vo_we  = hd_we;
    vo_wa  = (cmd == bc_pkg::CMD_SRC) ? '0 : tail_r[VW-1:0];
    vo_wd  = (cmd == bc_pkg::CMD_SRC) ? s_r[VW-1:0] : w_r;

    edge_we  = cmd == bc_pkg::CMD_ACCEPT && in_action == bc_pkg::ACT_ADD && !full;
    edge_re  = cmd == bc_pkg::CMD_EDGE && e_r != ec_r;
    score_addr = (cmd == bc_pkg::CMD_ACCEPT) ? in_vertex_a : w_r;
    score_re = cmd == bc_pkg::CMD_ACCEPT || cmd == bc_pkg::CMD_SRD;

    stat.queue_empty  = head_r == tail_r;
    stat.edges_done   = e_r == ec_r;
    stat.fwd_hit      = fwd_hit;
    stat.bwd_hit      = bwd_hit;
    stat.last_side    = side_r;
    stat.acc_ok       = acc_ok;
    stat.div_done     = !div_busy;
    stat.index_zero   = i_r == '0;
    stat.w_is_src     = {1'b0, w_r} == s_r;
    stat.sources_done = src_done;
    stat.out_pending  = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[ec_r[bc_pkg::EADDR_W-1:0]] <= {in_vertex_a, in_vertex_b};
    if (edge_re) edge_rd_r <= edge_mem[e_r[bc_pkg::EADDR_W-1:0]];
    if (hd_we)  hd_mem[vwr_addr]  <= hd_wd;
    if (pc_we)  pc_mem[vwr_addr]  <= pc_wd;
    if (dep_we) dep_mem[vwr_addr] <= dep_wd;
    if (vrd_en) begin
      hd_rd_r  <= hd_mem[vrd_addr];
      pc_rd_r  <= pc_mem[vrd_addr];
      dep_rd_r <= dep_mem[vrd_addr];
    end
    if (vo_we) vo_mem[vo_wa] <= vo_wd;
    if (cmd == bc_pkg::CMD_FPOP && !stat.queue_empty) vo_rd_r <= vo_mem[head_r[VW-1:0]];
    if (cmd == bc_pkg::CMD_BPOP && !stat.index_zero) vo_rd_r <= vo_mem[VW'(i_r - 1'b1)];
    if (cmd == bc_pkg::CMD_SWR) score_mem[w_r] <= bc_pkg::sat_add(score_base, depw_r);
    if (score_re) begin
      score_rd_r <= score_mem[score_addr];
      live_rd_r  <= live_r[score_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      directed_r  <= 1'b0;
      ec_r        <= '0;
      vs_r        <= '0;
      sv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) directed_r <= cfg_directed;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (cmd)
        bc_pkg::CMD_ACCEPT: begin
          act_r <= in_action;
          va_r  <= in_vertex_a;
          st_r  <= bc_pkg::ST_OK;
          if (in_action == bc_pkg::ACT_CLEAR) begin
            ec_r <= '0;
            vs_r <= '0;
            sv_r <= 1'b0;
          end else if (in_action == bc_pkg::ACT_ADD) begin
            if (full) begin
              st_r <= bc_pkg::ST_FULL;
            end else begin
              ec_r <= ec_r + 1'b1;
              if (top_v > vs_r) vs_r <= top_v;
              sv_r <= 1'b0;
            end
          end
        end
        bc_pkg::CMD_RESP: begin
          out_valid_r  <= 1'b1;
          out_count_r  <= vs_r;
          out_cent_r   <= '0;
          out_status_r <= st_r;
          if (act_r == bc_pkg::ACT_READ) begin
            if (!sv_r) begin
              out_status_r <= bc_pkg::ST_NOT_COMPUTED;
            end else if ({1'b0, va_r} >= vs_r) begin
              out_status_r <= bc_pkg::ST_RANGE;
            end else begin
              out_cent_r <= score_val;
            end
          end
        end
        bc_pkg::CMD_CINIT: begin
          live_r  <= '0;
          s_r     <= '0;
          halve_r <= !directed_r;
        end
        bc_pkg::CMD_SRC: begin
          if (src_done) begin
            sv_r <= 1'b1;
          end else begin
            for (int k = 0; k < NV; k++) reached_r[k] <= (k == int'(s_r));
            head_r <= '0;
            tail_r <= bc_pkg::VCNT_W'(1);
          end
        end
        bc_pkg::CMD_FPOP: if (!stat.queue_empty) head_r <= head_r + 1'b1;
        bc_pkg::CMD_FPOPW: v_r <= vo_rd_r;
        bc_pkg::CMD_FVLAT: begin
          hdv_r <= hd_rd_r;
          pcv_r <= pc_rd_r;
          e_r   <= '0;
        end
        bc_pkg::CMD_EDGE: side_r <= 1'b0;
        bc_pkg::CMD_EDGEW: begin
          a_r <= edge_rd_r[2*VW-1:VW];
          b_r <= edge_rd_r[VW-1:0];
        end
        bc_pkg::CMD_FCAND: w_r <= fcand_w;
        bc_pkg::CMD_FVIS: begin
          if (new_w) begin
            reached_r[w_r] <= 1'b1;
            tail_r <= tail_r + 1'b1;
          end
        end
        bc_pkg::CMD_ADV: begin
          if (side_r) e_r <= e_r + 1'b1;
          side_r <= !side_r;
        end
        bc_pkg::CMD_BINIT: i_r <= tail_r;
        bc_pkg::CMD_BPOP: begin
          if (stat.index_zero) s_r <= s_r + 1'b1;
          else i_r <= i_r - 1'b1;
        end
        bc_pkg::CMD_BPOPW: w_r <= vo_rd_r;
        bc_pkg::CMD_BWLAT: begin
          hdw_r     <= hd_rd_r;
          pcw_r     <= pc_rd_r;
          depw_r    <= dep_rd_r;
          oneplus_r <= bc_pkg::sat_add(bc_pkg::FIX_ONE, dep_rd_r);
          e_r       <= '0;
        end
        bc_pkg::CMD_BCAND: v_r <= bcand_v;
        bc_pkg::CMD_BCHK: begin
          pcv_r  <= pc_rd_r;
          depv_r <= dep_rd_r;
        end
        bc_pkg::CMD_BMUL: prod_r <= pcv_r * oneplus_r;
        bc_pkg::CMD_SWR: live_r[w_r] <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_vertex_count = out_count_r;
  assign out_centrality   = out_cent_r;

endmodule

### rtl/core/bc_ctrl.sv
module bc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_action,
  output logic             in_ready,
  input  bc_pkg::dp_stat_t stat,
  output bc_pkg::cmd_t     cmd
);

  bc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = bc_pkg::CMD_NONE;
    in_ready  = 1'b0;
    case (state_r)
      bc_pkg::S_IDLE: begin
        in_ready = !stat.out_pending;
        if (in_valid && !stat.out_pending) begin
          cmd = bc_pkg::CMD_ACCEPT;
          state_nxt = (in_action == bc_pkg::ACT_COMPUTE) ? bc_pkg::S_CINIT : bc_pkg::S_RESP;
        end
      end
      bc_pkg::S_RESP: begin
        cmd = bc_pkg::CMD_RESP;
        state_nxt = bc_pkg::S_IDLE;
      end
      bc_pkg::S_CINIT: begin
        cmd = bc_pkg::CMD_CINIT;
        state_nxt = bc_pkg::S_CSRC;
      end
      bc_pkg::S_CSRC: begin
        cmd = bc_pkg::CMD_SRC;
        state_nxt = stat.sources_done ? bc_pkg::S_RESP : bc_pkg::S_FPOP;
      end
      bc_pkg::S_FPOP: begin
        cmd = bc_pkg::CMD_FPOP;
        state_nxt = stat.queue_empty ? bc_pkg::S_BINIT : bc_pkg::S_FPOPW;
      end
      bc_pkg::S_FPOPW: begin
        cmd = bc_pkg::CMD_FPOPW;
        state_nxt = bc_pkg::S_FVLAT;
      end
      bc_pkg::S_FVLAT: begin
        cmd = bc_pkg::CMD_FVLAT;
        state_nxt = bc_pkg::S_FEDGE;
      end
      bc_pkg::S_FEDGE: begin
        cmd = bc_pkg::CMD_EDGE;
        state_nxt = stat.edges_done ? bc_pkg::S_FPOP : bc_pkg::S_FEDGEW;
      end
      bc_pkg::S_FEDGEW: begin
        cmd = bc_pkg::CMD_EDGEW;
        state_nxt = bc_pkg::S_FCAND;
      end
      bc_pkg::S_FCAND: begin
        cmd = bc_pkg::CMD_FCAND;
        state_nxt = stat.fwd_hit ? bc_pkg::S_FVIS : bc_pkg::S_FADV;
      end
      bc_pkg::S_FVIS: begin
        cmd = bc_pkg::CMD_FVIS;
        state_nxt = bc_pkg::S_FADV;
      end
      bc_pkg::S_FADV: begin
        cmd = bc_pkg::CMD_ADV;
        state_nxt = stat.last_side ? bc_pkg::S_FEDGE : bc_pkg::S_FCAND;
      end
      bc_pkg::S_BINIT: begin
        cmd = bc_pkg::CMD_BINIT;
        state_nxt = bc_pkg::S_BPOP;
      end
      bc_pkg::S_BPOP: begin
        cmd = bc_pkg::CMD_BPOP;
        state_nxt = stat.index_zero ? bc_pkg::S_CSRC : bc_pkg::S_BPOPW;
      end
      bc_pkg::S_BPOPW: begin
        cmd = bc_pkg::CMD_BPOPW;
        state_nxt = bc_pkg::S_BWLAT;
      end
      bc_pkg::S_BWLAT: begin
        cmd = bc_pkg::CMD_BWLAT;
        state_nxt = bc_pkg::S_BEDGE;
      end
      bc_pkg::S_BEDGE: begin
        cmd = bc_pkg::CMD_EDGE;
        state_nxt = stat.edges_done ? bc_pkg::S_BSRD : bc_pkg::S_BEDGEW;
      end
      bc_pkg::S_BEDGEW: begin
        cmd = bc_pkg::CMD_EDGEW;
        state_nxt = bc_pkg::S_BCAND;
      end
      bc_pkg::S_BCAND: begin
        cmd = bc_pkg::CMD_BCAND;
        state_nxt = stat.bwd_hit ? bc_pkg::S_BCHK : bc_pkg::S_BADV;
      end
      bc_pkg::S_BCHK: begin
        cmd = bc_pkg::CMD_BCHK;
        state_nxt = stat.acc_ok ? bc_pkg::S_BMUL : bc_pkg::S_BADV;
      end
      bc_pkg::S_BMUL: begin
        cmd = bc_pkg::CMD_BMUL;
        state_nxt = bc_pkg::S_BDIVI;
      end
      bc_pkg::S_BDIVI: begin
        cmd = bc_pkg::CMD_DIVSTART;
        state_nxt = bc_pkg::S_BDIV;
      end
      bc_pkg::S_BDIV: begin
        if (stat.div_done) state_nxt = bc_pkg::S_BACC;
      end
      bc_pkg::S_BACC: begin
        cmd = bc_pkg::CMD_BACC;
        state_nxt = bc_pkg::S_BADV;
      end
      bc_pkg::S_BADV: begin
        cmd = bc_pkg::CMD_ADV;
        state_nxt = stat.last_side ? bc_pkg::S_BEDGE : bc_pkg::S_BCAND;
      end
      bc_pkg::S_BSRD: begin
        cmd = bc_pkg::CMD_SRD;
        state_nxt = stat.w_is_src ? bc_pkg::S_BPOP : bc_pkg::S_BSWR;
      end
      bc_pkg::S_BSWR: begin
        cmd = bc_pkg::CMD_SWR;
        state_nxt = bc_pkg::S_BPOP;
      end
      default: state_nxt = bc_pkg::S_IDLE;
    endcase
  end

endmodule

### rtl/core/betweenness_centrality.sv
// Betweenness centrality engine for an unweighted multigraph.
// The in_ch channel carries one command per transfer: clear graph, add edge,
// compute, or read the centrality of one vertex. Every command gives exactly
// one transfer on out_ch with a status, the vertex count and, for a good read,
// the score in unsigned Q16.16.
// The cfg_ch channel writes the directed mode bit; it is always ready, and
// the user must write it only while the block is idle; this is not enforced.
// Clear, add and read pass through the accept state, which writes the edge
// store for an add or reads the score store, and the response state, which
// loads the output register. A new command is taken once the result has been
// transferred. Compute runs one source at a time through a state machine.
// Each queued vertex costs a scan of the edge store, and each predecessor
// found in the reverse pass costs a division in the serial divider.
// Reset clears the edge count, the vertex count, the scores valid flag, the
// mode bit and the output valid flag. While out_ch is stalled the result
// holds and no further command is accepted.
module betweenness_centrality (
  input  logic     clk,
  input  logic     rst_n,
  bc_in_if.sink    in_ch,
  bc_out_if.source out_ch,
  bc_cfg_if.sink   cfg_ch
);

  bc_pkg::cmd_t     cmd;
  bc_pkg::dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  bc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bc_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_action        (in_ch.action),
    .in_vertex_a      (in_ch.vertex_a),
    .in_vertex_b      (in_ch.vertex_b),
    .cfg_we           (cfg_ch.valid),
    .cfg_directed     (cfg_ch.directed_mode),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_status       (out_ch.status),
    .out_vertex_count (out_ch.vertex_count),
    .out_centrality   (out_ch.centrality)
  );

endmodule

### rtl/core/bc_checker.sv
module bc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [8:0]  out_vertex_count,
  input logic [31:0] out_centrality
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("command accepted while a result is pending");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted before the previous one finished");

  a_cent_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_centrality != 32'd0 |-> out_status == bc_pkg::ST_OK)
    else $error("nonzero centrality with error status");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_vertex_count <= 9'(bc_pkg::MAX_VERTICES))
    else $error("vertex count out of range");

endmodule

bind betweenness_centrality bc_checker u_bc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_vertex_count (out_ch.vertex_count),
  .out_centrality   (out_ch.centrality)
);
